// ===== src/tlm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlm_pkg
// shared constants and types for the two-level mmu with aging replacement
// ----------------------------------------------------------------------------
package tlm_pkg;

   localparam int PageBytesDef   = 16;
   localparam int FirstEntriesDef  = 4;
   localparam int SecondEntriesDef = 16;
   localparam int BlockCountDef  = 8;
   localparam int AgeBitsDef     = 32;

   localparam int KindW = 3;
   localparam int VaW   = 16;
   localparam int PidW  = 4;
   localparam int ProtW = 3;
   localparam int StatW = 3;
   localparam int PhysW = 7;
   localparam int PageW = 6;
   localparam int BlkW  = 3;

   localparam logic [KindW-1:0] KIND_READ  = 3'd0;
   localparam logic [KindW-1:0] KIND_WRITE = 3'd1;
   localparam logic [KindW-1:0] KIND_EXEC  = 3'd2;
   localparam logic [KindW-1:0] KIND_ATTR  = 3'd3;

   localparam logic [StatW-1:0] ST_OK       = 3'd0;
   localparam logic [StatW-1:0] ST_BOUNDS   = 3'd1;
   localparam logic [StatW-1:0] ST_RD_DENY  = 3'd2;
   localparam logic [StatW-1:0] ST_INVALID  = 3'd5;
   localparam logic [StatW-1:0] ST_OWNER    = 3'd6;

   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [VaW-1:0]   virtual_address;
      logic [PidW-1:0]  process_id;
      logic [ProtW-1:0] protection;
   } req_type;

   typedef struct packed {
      logic [StatW-1:0] status;
      logic [PhysW-1:0] physical_address;
      logic [PageW-1:0] page_index;
      logic             fault;
      logic [BlkW-1:0]  loaded_block;
      logic             replaced;
      logic             writeback;
      logic [PageW-1:0] victim_page;
   } rsp_type;

endpackage

// ===== src/tlm_if.sv =====
// ----------------------------------------------------------------------------
// tlm_if
// valid/ready channel carrying one word of a given payload type
// ----------------------------------------------------------------------------
interface tlm_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/two_level_mmu_aging_lru_core.sv =====
// ----------------------------------------------------------------------------
// two_level_mmu_aging_lru_core
// two-level page translation with aging-count page replacement
// ----------------------------------------------------------------------------
// one request word in, one response word out. the page table lives in one
// synchronous memory (present, dirty, block, age, rights, owner per page)
// and every in-bounds request is handled by a sequencer that walks it: a
// lookup read, then for a fault with no free block a victim scan over every
// page and a short evict step, then an aging sweep that reads, shifts and
// writes each page back. attribute loads and owner mismatches end after the
// lookup with no sweep, and out-of-bounds requests are answered with no
// lookup. after reset a clearing pass of one page per cycle over every page
// runs before the first request is taken. a new request is taken only once
// the last response word has left.
module two_level_mmu_aging_lru_core
   import tlm_pkg::*;
#(
   parameter int PAGE_BYTES           = PageBytesDef,
   parameter int FIRST_LEVEL_ENTRIES  = FirstEntriesDef,
   parameter int SECOND_LEVEL_ENTRIES = SecondEntriesDef,
   parameter int BLOCK_COUNT          = BlockCountDef,
   parameter int AGE_BITS             = AgeBitsDef
) (
   input logic clock,
   input logic reset,
   tlm_if.sink   req,
   tlm_if.source rsp
);

   localparam int Pages = FIRST_LEVEL_ENTRIES * SECOND_LEVEL_ENTRIES;
   localparam int PgW   = (Pages > 1) ? $clog2(Pages) : 1;
   localparam int BW    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int OffW  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
   localparam int Span  = PAGE_BYTES * SECOND_LEVEL_ENTRIES;
   localparam int Limit = Span * FIRST_LEVEL_ENTRIES;

   // one page-table entry
   typedef struct packed {
      logic                present;
      logic                dirty;
      logic [BW-1:0]       block;
      logic [AGE_BITS-1:0] age;
      logic [ProtW-1:0]    rights;
      logic [PidW-1:0]     owner;
   } pte_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_DEC, S_SCAN, S_SCANW, S_EVICT,
      S_AGE, S_AGEW, S_RESP
   } state_type;

   pte_type mem [Pages];
   pte_type rd_ff;
   pte_type look_ff;

   state_type state_ff;
   req_type   q_ff;
   rsp_type   out_ff;
   logic      out_valid_ff;
   logic [PgW-1:0] page_ff;
   logic [OffW-1:0] off_ff;
   logic [PgW:0]   cnt_ff;
   logic [BLOCK_COUNT-1:0] used_ff;
   logic           found_ff;
   logic [AGE_BITS-1:0] best_ff;
   logic [PgW-1:0] vic_ff;
   logic [BW-1:0]  blk_ff;

   // memory port
   logic           we;
   logic [PgW-1:0] waddr;
   logic [PgW-1:0] raddr;
   logic           re;
   pte_type        wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_ff <= mem[raddr];
   end

   // address split
   logic [VaW-1:0] va_first, va_rem;
   logic [PgW-1:0] va_page;
   always_comb begin
      va_first = req.payload.virtual_address / VaW'(Span);
      va_rem   = req.payload.virtual_address % VaW'(Span);
      va_page  = PgW'(va_first * VaW'(SECOND_LEVEL_ENTRIES) + va_rem / VaW'(PAGE_BYTES));
   end

   // bounds check and the first form of the response word
   logic    oob;
   rsp_type first_rsp;
   always_comb begin
      oob = (Limit <= 65535) ? (req.payload.virtual_address >= VaW'(Limit)) : 1'b0;
      first_rsp = '0;
      if (oob) first_rsp.status = ST_BOUNDS;
      else     first_rsp.page_index = PageW'(va_page);
   end

   // lowest free block
   logic           free_any;
   logic [BW-1:0]  free_blk;
   always_comb begin
      free_any = 1'b0;
      free_blk = '0;
      for (int i = BLOCK_COUNT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_blk = BW'(i);
         end
      end
   end

   logic req_ready;
   assign req_ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign req.ready = req_ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   logic [KindW-1:0] kind;
   assign kind = q_ff.kind;

   // memory control
   always_comb begin
      we    = 1'b0;
      waddr = cnt_ff[PgW-1:0];
      wdata = rd_ff;
      re    = 1'b0;
      raddr = page_ff;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            wdata = '0;
         end
         S_IDLE: begin
            re = 1'b1;
            raddr = va_page;
         end
         S_SCAN: begin
            re = 1'b1;
            raddr = cnt_ff[PgW-1:0];
         end
         S_AGE: begin
            re = 1'b1;
            raddr = cnt_ff[PgW-1:0];
         end
         S_DEC: begin
            if (kind == KIND_ATTR) begin
               we = 1'b1;
               waddr = page_ff;
               wdata = rd_ff;
               wdata.rights = q_ff.protection;
               wdata.owner  = q_ff.process_id;
            end else if (rd_ff.owner == q_ff.process_id && !rd_ff.present && free_any) begin
               we = 1'b1;
               waddr = page_ff;
               wdata = rd_ff;
               wdata.present = 1'b1;
               wdata.dirty = 1'b0;
               wdata.block = free_blk;
               wdata.age = '0;
            end
         end
         S_EVICT: begin
            if (cnt_ff == (PgW+1)'(0)) begin
               // fetch the victim entry
               re = 1'b1;
               raddr = vic_ff;
            end else if (cnt_ff == (PgW+1)'(2)) begin
               // victim out
               we = 1'b1;
               waddr = vic_ff;
               wdata = rd_ff;
               wdata.present = 1'b0;
               wdata.dirty = 1'b0;
               wdata.age = '0;
            end else begin
               // faulting page in, keeping its rights and owner
               we = 1'b1;
               waddr = page_ff;
               wdata = look_ff;
               wdata.present = 1'b1;
               wdata.dirty = 1'b0;
               wdata.block = blk_ff;
               wdata.age = '0;
            end
         end
         S_AGEW: begin
            we = 1'b1;
            waddr = cnt_ff[PgW-1:0];
            wdata = rd_ff;
            wdata.age = rd_ff.age >> 1;
            if (cnt_ff[PgW-1:0] == page_ff) begin
               if (kind <= KIND_EXEC) begin
                  wdata.age[AGE_BITS-1] = 1'b1;
                  if (kind == KIND_WRITE && rd_ff.rights[1]) wdata.dirty = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         used_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp.ready && out_valid_ff) out_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == (PgW+1)'(Pages - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req.valid && req_ready) begin
                  q_ff <= req.payload;
                  page_ff <= va_page;
                  off_ff <= OffW'(req.payload.virtual_address % VaW'(PAGE_BYTES));
                  out_ff <= first_rsp;
                  if (oob) state_ff <= S_RESP;
                  else     state_ff <= S_LOOK;
               end
            end
            S_LOOK: state_ff <= S_DEC;
            S_DEC: begin
               cnt_ff <= '0;
               found_ff <= 1'b0;
               look_ff <= rd_ff;
               if (kind == KIND_ATTR) begin
                  state_ff <= S_RESP;
               end else if (rd_ff.owner != q_ff.process_id) begin
                  out_ff.status <= ST_OWNER;
                  state_ff <= S_RESP;
               end else if (rd_ff.present) begin
                  state_ff <= S_AGE;
               end else begin
                  out_ff.fault <= 1'b1;
                  if (free_any) begin
                     used_ff[free_blk] <= 1'b1;
                     blk_ff <= free_blk;
                     out_ff.loaded_block <= BlkW'(free_blk);
                     state_ff <= S_AGE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: state_ff <= S_SCANW;
            S_SCANW: begin
               // minimum age among present pages, lowest index on a tie
               if (rd_ff.present && (!found_ff || rd_ff.age < best_ff)) begin
                  found_ff <= 1'b1;
                  best_ff <= rd_ff.age;
                  vic_ff <= cnt_ff[PgW-1:0];
               end
               if (cnt_ff == (PgW+1)'(Pages - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= S_EVICT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  state_ff <= S_SCAN;
               end
            end
            S_EVICT: begin
               if (cnt_ff == (PgW+1)'(0)) begin
                  if (found_ff) begin
                     cnt_ff <= (PgW+1)'(2);
                  end else begin
                     // no victim: block 0 and nothing replaced
                     cnt_ff <= (PgW+1)'(1);
                     blk_ff <= '0;
                     out_ff.loaded_block <= '0;
                  end
               end else if (cnt_ff == (PgW+1)'(2)) begin
                  out_ff.replaced <= 1'b1;
                  out_ff.writeback <= rd_ff.dirty;
                  out_ff.victim_page <= PageW'(vic_ff);
                  out_ff.loaded_block <= BlkW'(rd_ff.block);
                  blk_ff <= rd_ff.block;
                  cnt_ff <= (PgW+1)'(1);
               end else begin
                  cnt_ff <= '0;
                  state_ff <= S_AGE;
               end
            end
            S_AGE: state_ff <= S_AGEW;
            S_AGEW: begin
               if (cnt_ff[PgW-1:0] == page_ff) begin
                  blk_ff <= rd_ff.block;
                  if (kind <= KIND_EXEC) begin
                     if (!rd_ff.rights[kind[1:0]])
                        out_ff.status <= ST_RD_DENY + kind;
                  end else begin
                     out_ff.status <= ST_INVALID;
                  end
               end
               if (cnt_ff == (PgW+1)'(Pages - 1)) begin
                  state_ff <= S_RESP;
                  out_ff.physical_address <= PhysW'(
                     (cnt_ff[PgW-1:0] == page_ff ? rd_ff.block : blk_ff) * PAGE_BYTES
                     + off_ff);
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  state_ff <= S_AGE;
               end
            end
            S_RESP: begin
               out_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
